// ===== rtl/assert_macros.svh =====
// Assertion macros used by the ALU core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/fpalu_pkg.sv =====
// Package of types, codes and constants shared by the fixed-point ALU files.
package fpalu_pkg;
	localparam int OpBits = 4;
	localparam logic [OpBits-1:0] OP_ADD = 4'd0;
	localparam logic [OpBits-1:0] OP_SUB = 4'd1;
	localparam logic [OpBits-1:0] OP_MUL = 4'd2;
	localparam logic [OpBits-1:0] OP_DIV = 4'd3;
	localparam logic [OpBits-1:0] OP_INC = 4'd4;
	localparam logic [OpBits-1:0] OP_DEC = 4'd5;
	localparam logic [OpBits-1:0] OP_MIN = 4'd6;
	localparam logic [OpBits-1:0] OP_MAX = 4'd7;
	localparam logic [OpBits-1:0] OP_FROM_INT = 4'd8;
	localparam logic [OpBits-1:0] OP_TO_INT = 4'd9;

	// Flags travelling with every item through the chain.
	typedef struct packed {
		logic less;
		logic greater;
		logic equal;
		logic overflow;
		logic div_by_zero;
	} flags_t;
endpackage

// ===== rtl/fixed_point_alu_core.sv =====
// Top level of the fixed-point ALU: front stage, divider cell chain, result stage.
//
// Signed fixed-point ALU on WORD_BITS raw words with FRAC_BITS fraction bits. It takes
// one word per cycle unless the output stalls, and returns one result word per input word,
// in order. Every word passes the same pipeline: one input stage, the multiplier stage
// and a chain of WORD_BITS + FRAC_BITS division cells (one quotient bit each), with
// quotient rounding and result selection in front of the output register; that chain
// sets the latency. The whole pipeline stalls only when the output register is
// full and not taken.
module fixed_point_alu_core #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// operation[3:0], operand_a[35:4], operand_b[67:36], zero pad
	input  logic [((fpalu_pkg::OpBits + 2 * WORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result[31:0], less, greater, equal, overflow, div_by_zero, zero pad
	output logic [((WORD_BITS + 5 + 7) / 8) * 8 - 1:0] m_tdata
);
	`include "assert_macros.svh"

	localparam int W = WORD_BITS;
	localparam int F = FRAC_BITS;
	localparam int NB = W + F;        // dividend bits
	localparam int PB = 2 * W;        // product bits
	localparam int OutBits = ((W + 5 + 7) / 8) * 8;
	localparam int MetaBits = fpalu_pkg::OpBits + 2 * W + 5 + 5;

	// Saturation constants.
	localparam logic [W-1:0] MaxW = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MinW = {1'b1, {(W-1){1'b0}}};

	logic adv;
	logic [W-1:0] a_in, b_in;
	logic [fpalu_pkg::OpBits-1:0] op_in;

	assign op_in = s_tdata[fpalu_pkg::OpBits-1:0];
	assign a_in  = s_tdata[fpalu_pkg::OpBits +: W];
	assign b_in  = s_tdata[fpalu_pkg::OpBits + W +: W];

	logic m_valid_q;
	assign adv = !m_valid_q || m_tready;
	assign s_tready = adv;

	// Saturating pack of a sign and an unsigned magnitude.
	function automatic logic [W:0] pack_sat(input logic neg, input logic [NB+1:0] mag);
		logic [W:0] r;
		begin
			if (neg) begin
				if (mag > {{(NB+2-W){1'b0}}, MinW}) r = {1'b1, MinW};
				else r = {1'b0, W'(-mag[W-1:0])};
			end else begin
				if (mag > {{(NB+2-W){1'b0}}, MaxW}) r = {1'b1, MaxW};
				else r = {1'b0, mag[W-1:0]};
			end
			return r;
		end
	endfunction

	// Stage 1: register operands, magnitudes and the easy results.
	logic vld_s1;
	logic [fpalu_pkg::OpBits-1:0] op_s1;
	logic sa_s1, sb_s1;
	logic [W-1:0] ma_s1, mb_s1, easy_s1;
	logic easy_ovf_s1;
	fpalu_pkg::flags_t fl_s1;

	logic sa, sb;
	logic [W-1:0] ma, mb;
	logic signed [W:0] ssum;
	logic signed [W:0] sdif;
	logic lt, gt;
	logic [W:0] pk;
	logic [W-1:0] easy;
	logic easy_ovf;

	always_comb begin
		sa = a_in[W-1];
		sb = b_in[W-1];
		ma = sa ? W'(-a_in) : a_in;
		mb = sb ? W'(-b_in) : b_in;
		lt = $signed(a_in) < $signed(b_in);
		gt = $signed(a_in) > $signed(b_in);
		ssum = $signed({a_in[W-1], a_in}) + $signed({b_in[W-1], b_in});
		sdif = $signed({a_in[W-1], a_in}) - $signed({b_in[W-1], b_in});
		easy = '0;
		easy_ovf = 1'b0;
		pk = '0;
		unique case (op_in)
			fpalu_pkg::OP_ADD: begin
				easy = ssum[W-1:0];
				easy_ovf = ssum[W] != ssum[W-1];
				if (easy_ovf) easy = ssum[W] ? MinW : MaxW;
			end
			fpalu_pkg::OP_SUB: begin
				easy = sdif[W-1:0];
				easy_ovf = sdif[W] != sdif[W-1];
				if (easy_ovf) easy = sdif[W] ? MinW : MaxW;
			end
			fpalu_pkg::OP_INC: begin
				easy_ovf = a_in == MaxW;
				easy = easy_ovf ? MaxW : a_in + W'(1);
			end
			fpalu_pkg::OP_DEC: begin
				easy_ovf = a_in == MinW;
				easy = easy_ovf ? MinW : a_in - W'(1);
			end
			fpalu_pkg::OP_MIN: easy = lt ? a_in : b_in;
			fpalu_pkg::OP_MAX: easy = gt ? a_in : b_in;
			fpalu_pkg::OP_FROM_INT: begin
				pk = pack_sat(sa, {{2{1'b0}}, ma, {F{1'b0}}});
				easy = pk[W-1:0];
				easy_ovf = pk[W];
			end
			fpalu_pkg::OP_TO_INT: easy = W'($signed(a_in) >>> F);
			default: begin
				easy = '0;
				easy_ovf = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= op_in;
			sa_s1 <= sa;
			sb_s1 <= sb;
			ma_s1 <= ma;
			mb_s1 <= mb;
			easy_s1 <= easy;
			easy_ovf_s1 <= easy_ovf;
			fl_s1 <= '{less: lt, greater: gt, equal: a_in == b_in,
				overflow: 1'b0, div_by_zero: 1'b0};
		end
	end

	// Stage 2: multiply magnitudes, round and pack the product.
	logic vld_s2;
	logic [W-1:0] mul_s2;
	logic mul_ovf_s2;
	logic [PB-1:0] prod;
	logic [PB:0] prod_r;
	logic [W:0] mpk;

	always_comb begin
		prod = PB'(ma_s1) * PB'(mb_s1);
		prod_r = {1'b0, prod} + ((PB+1)'(1) << (F - 1));
		mpk = pack_sat(sa_s1 != sb_s1, (NB+2)'(prod_r >> F));
		if ((prod_r >> F) > (PB+1)'(MinW)) mpk = {1'b1, (sa_s1 != sb_s1) ? MinW : MaxW};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	// Side data for the divider chain: op, easy result, product, flags, the product and easy
	// overflow bits, signs and a non-zero dividend mark.
	logic [MetaBits-1:0] meta_s2;
	logic [NB-1:0] num_s2;
	logic [W-1:0] den_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			mul_s2 <= mpk[W-1:0];
			mul_ovf_s2 <= mpk[W];
			num_s2 <= {ma_s1, {F{1'b0}}};
			den_s2 <= mb_s1;
			meta_s2 <= {op_s1, easy_s1, mpk[W-1:0], fl_s1, mpk[W], easy_ovf_s1,
				sa_s1, sb_s1, ma_s1 != '0};
		end
	end

	// Divider chain: one cell per quotient bit.
	logic [NB:0] c_vld;
	logic [NB-1:0] c_num [NB+1];
	logic [W:0] c_rem [NB+1];
	logic [W-1:0] c_den [NB+1];
	logic [MetaBits-1:0] c_meta [NB+1];

	assign c_vld[0] = vld_s2;
	assign c_num[0] = num_s2;
	assign c_rem[0] = '0;
	assign c_den[0] = den_s2;
	assign c_meta[0] = meta_s2;

	for (genvar k = 0; k < NB; k++) begin : g_chain
		fpalu_div_cell #(.NumBits(NB), .DenBits(W)) u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.vld_in(c_vld[k]), .num_in(c_num[k]), .rem_in(c_rem[k]), .den_in(c_den[k]),
			.vld_q(c_vld[k+1]), .num_q(c_num[k+1]), .rem_q(c_rem[k+1]),
			.den_q(c_den[k+1])
		);
		fpalu_delay_cell #(.Width(MetaBits)) u_meta (
			.clk(clk), .adv(adv), .d(c_meta[k]), .q(c_meta[k+1])
		);
	end

	// Final stage: round the quotient, pick the result and register the output word.
	logic [fpalu_pkg::OpBits-1:0] f_op;
	logic [W-1:0] f_easy, f_mul;
	fpalu_pkg::flags_t f_fl, o_fl;
	logic f_mov, f_eov, f_sa, f_sb, f_anz;
	logic [NB:0] qr;
	logic [W:0] dpk;
	logic [W-1:0] o_res;

	always_comb begin
		{f_op, f_easy, f_mul, f_fl, f_mov, f_eov, f_sa, f_sb, f_anz} = c_meta[NB];
		// Round half up: 2*rem >= den.
		qr = {1'b0, c_num[NB]} + (NB+1)'({c_rem[NB], 1'b0} >= {2'b00, c_den[NB]});
		dpk = pack_sat(f_sa != f_sb, (NB+2)'(qr));
		o_fl = f_fl;
		o_res = f_easy;
		o_fl.overflow = f_eov;
		if (f_op == fpalu_pkg::OP_MUL) begin
			o_res = f_mul;
			o_fl.overflow = f_mov;
		end else if (f_op == fpalu_pkg::OP_DIV) begin
			if (c_den[NB] == '0) begin
				o_fl.div_by_zero = 1'b1;
				o_fl.overflow = f_anz;
				o_res = !f_anz ? '0 : (f_sa ? MinW : MaxW);
			end else begin
				o_res = dpk[W-1:0];
				o_fl.overflow = dpk[W];
			end
		end
	end

	logic [W-1:0] res_q;
	fpalu_pkg::flags_t fl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= c_vld[NB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= o_res;
			fl_q <= o_fl;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = OutBits'({fl_q.div_by_zero, fl_q.overflow, fl_q.equal, fl_q.greater,
		fl_q.less, res_q});

	`ASSERT_IMPL(a_flags_excl, clk, arst_n, m_valid_q,
		$countones({fl_q.less, fl_q.greater, fl_q.equal}) == 1, "compare flags not one-hot")
	`ASSERT_NEXT(a_hold_stall, clk, arst_n, m_valid_q && !m_tready,
		m_valid_q && $stable(res_q), "output word changed under stall")
	`ASSERT_IMPL(a_dz_op, clk, arst_n, m_valid_q && fl_q.div_by_zero,
		!(fl_q.overflow && res_q == '0), "zero result flagged as overflow")
endmodule

// ===== rtl/fpalu_div_cell.sv =====
// One restoring-division cell: takes one quotient bit per clock while adv is high and hands on.
module fpalu_div_cell #(
	parameter int NumBits = 40,
	parameter int DenBits = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               vld_in,
	input  logic [NumBits-1:0] num_in,
	input  logic [DenBits:0]   rem_in,
	input  logic [DenBits-1:0] den_in,
	output logic               vld_q,
	output logic [NumBits-1:0] num_q,
	output logic [DenBits:0]   rem_q,
	output logic [DenBits-1:0] den_q
);
	logic [DenBits+1:0] shifted;
	logic [DenBits+1:0] diff;

	// Shift in the next dividend bit and trial-subtract the divisor.
	always_comb begin
		shifted = {rem_in, num_in[NumBits-1]};
		diff = shifted - {2'b00, den_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	// Advance the partial remainder; the freed low bit takes the quotient bit.
	always_ff @(posedge clk) begin
		if (adv) begin
			den_q <= den_in;
			if (!diff[DenBits+1]) begin
				rem_q <= diff[DenBits:0];
				num_q <= {num_in[NumBits-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DenBits:0];
				num_q <= {num_in[NumBits-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== rtl/fpalu_delay_cell.sv =====
// One delay cell carrying an item's side data alongside the divider chain.
module fpalu_delay_cell #(
	parameter int Width = 8
) (
	input  logic             clk,
	input  logic             adv,
	input  logic [Width-1:0] d,
	output logic [Width-1:0] q
);
	// Hold while stalled, advance otherwise.
	always_ff @(posedge clk) begin
		if (adv) begin
			q <= d;
		end
	end
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the fixed-point ALU core, with scoreboard and stimulus.
module tb;
	localparam int Frac = 8;
	localparam int WatchLimit = 6000;
	localparam logic signed [127:0] WordMax = 128'sd2147483647;
	localparam logic signed [127:0] WordMin = -128'sd2147483648;

	typedef struct packed {
		logic [31:0] result;
		fpalu_pkg::flags_t flags;
	} alu_word_t;

	// Expected ALU words in order of acceptance, checked against the output stream
	class alu_scoreboard;
		alu_word_t expected_q[$];
		int errors;

		function logic [31:0] clamp(input logic signed [127:0] v, inout logic ovf);
			if (v > WordMax) begin
				ovf = 1'b1;
				return WordMax[31:0];
			end
			if (v < WordMin) begin
				ovf = 1'b1;
				return WordMin[31:0];
			end
			return v[31:0];
		endfunction

		// Work out the result word for one accepted operation
		function alu_word_t compute(input logic [3:0] op,
				input logic signed [31:0] a, input logic signed [31:0] b);
			logic signed [127:0] wa, wb, mag, den, quo, rem;
			logic neg;
			alu_word_t w;
			wa = a;
			wb = b;
			w = '0;
			w.flags.less = a < b;
			w.flags.greater = a > b;
			w.flags.equal = a == b;
			case (op)
				fpalu_pkg::OP_ADD: w.result = clamp(wa + wb, w.flags.overflow);
				fpalu_pkg::OP_SUB: w.result = clamp(wa - wb, w.flags.overflow);
				fpalu_pkg::OP_MUL: begin
					mag = wa * wb;
					neg = mag < 0;
					if (neg)
						mag = -mag;
					mag = (mag + (128'sd1 <<< (Frac - 1))) >>> Frac;
					w.result = clamp(neg ? -mag : mag, w.flags.overflow);
				end
				fpalu_pkg::OP_DIV: begin
					if (wb == 0) begin
						w.flags.div_by_zero = 1'b1;
						if (wa > 0)
							w.result = clamp(WordMax + 1, w.flags.overflow);
						else if (wa < 0)
							w.result = clamp(WordMin - 1, w.flags.overflow);
					end else begin
						neg = (wa < 0) != (wb < 0);
						mag = (wa < 0 ? -wa : wa) <<< Frac;
						den = wb < 0 ? -wb : wb;
						quo = mag / den;
						rem = mag % den;
						// round half away from zero
						if (rem >= den - rem)
							quo = quo + 1;
						w.result = clamp(neg ? -quo : quo, w.flags.overflow);
					end
				end
				fpalu_pkg::OP_INC: w.result = clamp(wa + 1, w.flags.overflow);
				fpalu_pkg::OP_DEC: w.result = clamp(wa - 1, w.flags.overflow);
				fpalu_pkg::OP_MIN: w.result = a < b ? a : b;
				fpalu_pkg::OP_MAX: w.result = a > b ? a : b;
				fpalu_pkg::OP_FROM_INT: w.result = clamp(wa <<< Frac, w.flags.overflow);
				fpalu_pkg::OP_TO_INT: w.result = a >>> Frac;
				default: w.result = '0;
			endcase
			return w;
		endfunction

		function void note_operation(input logic [71:0] data);
			expected_q.push_back(compute(data[3:0], data[35:4], data[67:36]));
		endfunction

		function void check_result(input logic [39:0] data);
			alu_word_t exp_w, got;
			got.result = data[31:0];
			got.flags.less = data[32];
			got.flags.greater = data[33];
			got.flags.equal = data[34];
			got.flags.overflow = data[35];
			got.flags.div_by_zero = data[36];
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result word, actual %h", $time, data);
				errors++;
				return;
			end
			exp_w = expected_q.pop_front();
			if (got.result !== exp_w.result) begin
				$display("%0t: result mismatch, expected %h actual %h", $time,
					exp_w.result, got.result);
				errors++;
			end
			if (got.flags !== exp_w.flags) begin
				$display("%0t: flags mismatch (lt gt eq ovf dz), expected %b actual %b",
					$time, exp_w.flags, got.flags);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [71:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;

	alu_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	fixed_point_alu_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Drive the output ready, honouring any long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// Check each result word and watch for a hung pipeline
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WatchLimit) begin
				$display("fixed_point_alu_core verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic logic [31:0] pick_operand();
		logic [31:0] corners [9];
		corners = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000,
			32'h100, 32'hffffff00, 32'h7ffffffe, 32'h80000001};
		case ($urandom_range(9))
			0, 1, 2: return $urandom();
			3: return corners[$urandom_range(8)];
			4, 5, 6: return $signed($urandom_range(65535)) - 32'sd32768;
			default: return $signed($urandom_range(32'hffffff)) - 32'sd8388608;
		endcase
	endfunction

	// Offer one operation and wait for it to be taken
	task automatic send_word(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, b, a, op};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_operation(s_tdata);
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		logic [3:0] op;
		repeat (count) begin
			op = $urandom_range(19) == 0 ? 4'($urandom_range(15)) : 4'($urandom_range(9));
			send_word(op, pick_operand(), pick_operand());
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, every operation, zero divisor, limits, an unused code
		send_word(fpalu_pkg::OP_ADD, 32'h7fffffff, 32'h1);
		send_word(fpalu_pkg::OP_ADD, 32'h80000000, 32'hffffffff);
		send_word(fpalu_pkg::OP_SUB, 32'h80000000, 32'h1);
		send_word(fpalu_pkg::OP_SUB, 32'h7fffffff, 32'h80000000);
		send_word(fpalu_pkg::OP_MUL, 32'h180, 32'hfffffe80);
		send_word(fpalu_pkg::OP_MUL, 32'h7fffffff, 32'h7fffffff);
		send_word(fpalu_pkg::OP_MUL, 32'h80000000, 32'h100);
		send_word(fpalu_pkg::OP_MUL, 32'h1, 32'h80);
		send_word(fpalu_pkg::OP_DIV, 32'h100, 32'h0);
		send_word(fpalu_pkg::OP_DIV, 32'hffffff00, 32'h0);
		send_word(fpalu_pkg::OP_DIV, 32'h0, 32'h0);
		send_word(fpalu_pkg::OP_DIV, 32'h100, 32'h300);
		send_word(fpalu_pkg::OP_DIV, 32'h80000000, 32'h1);
		send_word(fpalu_pkg::OP_DIV, 32'hfffffd00, 32'h200);
		send_word(fpalu_pkg::OP_INC, 32'h7fffffff, 32'h0);
		send_word(fpalu_pkg::OP_DEC, 32'h80000000, 32'h0);
		send_word(fpalu_pkg::OP_MIN, 32'h5, 32'h5);
		send_word(fpalu_pkg::OP_MAX, 32'h80000000, 32'h7fffffff);
		send_word(fpalu_pkg::OP_MIN, 32'hffffffff, 32'h1);
		send_word(fpalu_pkg::OP_FROM_INT, 32'h7fffff, 32'h0);
		send_word(fpalu_pkg::OP_FROM_INT, 32'hff800000, 32'h0);
		send_word(fpalu_pkg::OP_FROM_INT, 32'h800000, 32'h0);
		send_word(fpalu_pkg::OP_TO_INT, 32'hfffffe01, 32'h0);
		send_word(fpalu_pkg::OP_TO_INT, 32'h80000000, 32'hffffffff);
		send_word(4'hf, 32'h12345678, 32'h12345678);

		// random phases: free flow, sparse sender, stalling receiver, long hold-off, both
		send_random(500);
		send_idle_pct = 88;
		send_random(300);
		send_idle_pct = 0;
		recv_stall_pct = 88;
		send_random(400);
		// long hold-off on the output so the pipeline fills and backs up
		recv_stall_pct = 0;
		hold_cycles = 300;
		send_random(250);
		send_idle_pct = 26;
		recv_stall_pct = 26;
		send_random(500);
		s_tvalid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0)
			$display("fixed_point_alu_core verification clean");
		else
			$display("fixed_point_alu_core verification failed");
		$finish;
	end
endmodule

// ===== fixed_point_alu_core.f =====
+incdir+rtl
rtl/fpalu_pkg.sv
rtl/fpalu_div_cell.sv
rtl/fpalu_delay_cell.sv
rtl/fixed_point_alu_core.sv
verif/tb.sv
